FILE: rtl/linked_block_file_allocator_macros.svh
// Assertion macros of the allocator top level.
// Depends on nothing; included inside module bodies.
`ifndef LINKED_BLOCK_FILE_ALLOCATOR_MACROS_SVH
`define LINKED_BLOCK_FILE_ALLOCATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LBFA_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
else $error(msg);
// Next-cycle implication.
`define LBFA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
else $error(msg);
`endif

FILE: rtl/lbfa_pkg.sv
// Shared types and codes of the linked block file allocator.
// Depends on nothing.
package lbfa_pkg;
    localparam logic [2:0] ST_CREATED  = 3'd0;
    localparam logic [2:0] ST_DELETED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOSPACE  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic       KIND_CREATE = 1'b0;
    localparam logic       KIND_DELETE = 1'b1;
    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  head_block;
        logic [10:0] chain_length;
        logic [10:0] blocks_in_use;
    } lbfa_result_t;
endpackage

FILE: rtl/linked_block_file_allocator.sv
// Top level of the linked block file allocator: sequencer and all memories.
// Depends on lbfa_pkg and linked_block_file_allocator_macros.svh.
//
//  Channel | Direction | Payload
//  s_axis  | in        | tuser=kind, tdata={byte_size, file_key}
//  m_axis  | out       | tdata={blocks_in_use, chain_length, head_block, status}
//
// One request at a time. A create first counts its blocks by taking off one block
// size per cycle, and stops early once the count passes the free blocks. It then
// scans the used map from block 0 at one block per cycle and closes the chain in a
// last state. A delete searches the table at one entry per cycle, walks the chain
// with a link memory read before each block, then compacts the table by reading
// and then writing each moved entry. After reset the whole used map is cleared
// while no request is taken.
// The result waits in an output register; s_axis_tready stays low until it is taken.
module linked_block_file_allocator #(
    parameter int DISK_BLOCKS     = 1024,
    parameter int TABLE_ENTRIES   = 1024,
    parameter int BYTES_PER_BLOCK = 1024,
    parameter int KEY_BYTES       = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // file_key[63:0], byte_size[87:64]
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // status, head_block, chain_length, blocks_in_use, pad
);
    import lbfa_pkg::*;
    `include "linked_block_file_allocator_macros.svh"

    localparam int BW = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;
    localparam int LW = $clog2(DISK_BLOCKS + 1);
    localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int KB = KEY_BYTES * 8;
    localparam logic [LW-1:0] END_LINK = LW'(DISK_BLOCKS);
    localparam logic [23:0]   BLK_SIZE = 24'(BYTES_PER_BLOCK);

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_DIV = 4'd2,
        S_SCAN_RD = 4'd3, S_SCAN = 4'd4, S_FIND_RD = 4'd5, S_FIND = 4'd6,
        S_WALK_RD = 4'd7, S_WALK = 4'd8, S_MOVE_RD = 4'd9, S_MOVE = 4'd10,
        S_OUT = 4'd11, S_TAIL = 4'd12;

    // Memories
    logic          used_mem [DISK_BLOCKS];
    logic [LW-1:0] link_mem [DISK_BLOCKS];
    logic [KB-1:0] key_mem  [TABLE_ENTRIES];
    logic [23:0]   size_mem [TABLE_ENTRIES];
    logic [LW-1:0] head_mem [TABLE_ENTRIES];

    logic [3:0]    state_reg, state_next;
    logic [BW-1:0] blk_reg;         // scan address
    logic [LW-1:0] cnt_reg;         // clear counter, chain length
    logic [EW-1:0] ent_reg;
    logic [CW-1:0] entry_count_reg;
    logic [LW-1:0] used_count_reg;
    logic [KB-1:0] key_reg;
    logic [23:0]   size_reg;
    logic [23:0]   rem_reg;         // bytes not yet covered by counted blocks
    logic [LW-1:0] need_reg;
    logic [LW-1:0] head_reg, prev_reg, cur_reg;
    logic [LW-1:0] steps_reg;
    lbfa_result_t  res_reg;

    // read data registers
    logic          used_rd;
    logic [LW-1:0] link_rd, head_rd;
    logic [KB-1:0] key_rd;
    logic [23:0]   size_rd;

    // memory control
    logic          used_we, used_wd;
    logic [BW-1:0] used_wa, used_ra;
    logic          link_we;
    logic [BW-1:0] link_wa, link_ra;
    logic [LW-1:0] link_wd;
    logic          ent_we;
    logic [EW-1:0] ent_wa, ent_ra;
    logic [KB-1:0] key_wd;
    logic [23:0]   size_wd;
    logic [LW-1:0] head_wd;

    always_ff @(posedge clk)
    begin
        if (used_we) used_mem[used_wa] <= used_wd;
        used_rd <= used_mem[used_ra];
        if (link_we) link_mem[link_wa] <= link_wd;
        link_rd <= link_mem[link_ra];
        if (ent_we)
        begin
            key_mem[ent_wa]  <= key_wd;
            size_mem[ent_wa] <= size_wd;
            head_mem[ent_wa] <= head_wd;
        end
        key_rd  <= key_mem[ent_ra];
        size_rd <= size_mem[ent_ra];
        head_rd <= head_mem[ent_ra];
    end

    logic in_acc, out_acc;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = {5'd0, res_reg.blocks_in_use, res_reg.chain_length,
                           res_reg.head_block, res_reg.status};

    logic [LW-1:0] avail;
    logic [EW:0]   ent_inc;
    logic [BW:0]   blk_inc;
    assign avail   = LW'(DISK_BLOCKS) - used_count_reg;
    assign ent_inc = {1'b0, ent_reg} + 1'b1;
    assign blk_inc = {1'b0, blk_reg} + 1'b1;

    // Outcome of the block count step: a full table wins over a short disk.
    logic [2:0] div_status;
    assign div_status = (entry_count_reg >= CW'(TABLE_ENTRIES)) ? ST_FULL :
                        ((rem_reg != '0) && (need_reg == avail)) ? ST_NOSPACE :
                        ST_CREATED;

    logic key_hit;
    assign key_hit = (key_rd == key_reg);

    always_comb
    begin
        state_next = state_reg;
        used_we = 1'b0; used_wd = 1'b0; used_wa = blk_reg; used_ra = blk_reg;
        link_we = 1'b0; link_wa = blk_reg; link_wd = END_LINK;
        link_ra = cur_reg[BW-1:0];
        ent_we = 1'b0; ent_wa = ent_reg; ent_ra = ent_reg;
        key_wd = key_rd; size_wd = size_rd; head_wd = head_rd;
        unique case (state_reg)
            S_CLEAR:
            begin
                used_we = 1'b1;
                used_wa = cnt_reg[BW-1:0];
                if (cnt_reg == LW'(DISK_BLOCKS - 1)) state_next = S_IDLE;
            end
            S_IDLE:
                if (in_acc)
                    state_next = (s_axis_tuser == KIND_CREATE) ? S_DIV : S_FIND_RD;
            S_DIV:
            begin
                if (entry_count_reg >= CW'(TABLE_ENTRIES)) state_next = S_OUT;
                else if (rem_reg != '0)
                begin
                    // One more block is needed; stop once it cannot fit.
                    if (need_reg == avail) state_next = S_OUT;
                end
                else if (need_reg == '0)
                begin
                    ent_we = 1'b1; ent_wa = entry_count_reg[EW-1:0];
                    key_wd = key_reg; size_wd = size_reg; head_wd = END_LINK;
                    state_next = S_OUT;
                end
                else state_next = S_SCAN_RD;
            end
            S_SCAN_RD: state_next = S_SCAN;
            S_SCAN:
            begin
                used_ra = blk_inc[BW-1:0];
                if (!used_rd)
                begin
                    used_we = 1'b1; used_wd = 1'b1;
                    // Hook this block onto the previous one of the chain.
                    link_we = (head_reg != END_LINK);
                    link_wa = prev_reg[BW-1:0];
                    link_wd = LW'(blk_reg);
                    if (cnt_reg + 1'b1 == need_reg)
                    begin
                        ent_we = 1'b1; ent_wa = entry_count_reg[EW-1:0];
                        key_wd = key_reg; size_wd = size_reg;
                        head_wd = (head_reg == END_LINK) ? LW'(blk_reg) : head_reg;
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                // Close the chain at its last block.
                link_we = 1'b1; link_wa = prev_reg[BW-1:0]; link_wd = END_LINK;
                state_next = S_OUT;
            end
            S_FIND_RD:
                state_next = (entry_count_reg == '0) ? S_OUT : S_FIND;
            S_FIND:
            begin
                ent_ra = ent_inc[EW-1:0];
                if (key_hit)
                    state_next = (head_rd == END_LINK) ? S_MOVE_RD : S_WALK_RD;
                else if (CW'(ent_inc) >= entry_count_reg) state_next = S_OUT;
            end
            S_WALK_RD: state_next = S_WALK;
            S_WALK:
            begin
                used_we = 1'b1; used_wa = cur_reg[BW-1:0]; used_wd = 1'b0;
                link_we = 1'b1; link_wa = cur_reg[BW-1:0]; link_wd = END_LINK;
                if (link_rd >= END_LINK || steps_reg + 1'b1 == END_LINK)
                    state_next = S_MOVE_RD;
                else state_next = S_WALK_RD;
            end
            S_MOVE_RD:
            begin
                ent_ra = ent_inc[EW-1:0];
                state_next = (CW'(ent_inc) >= entry_count_reg) ? S_OUT : S_MOVE;
            end
            S_MOVE:
            begin
                ent_we = 1'b1;
                ent_ra = ent_inc[EW-1:0];
                state_next = S_MOVE_RD;
            end
            S_OUT:
                if (out_acc) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            cnt_reg         <= '0;
            entry_count_reg <= '0;
            used_count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_CLEAR: cnt_reg <= cnt_reg + 1'b1;
                S_IDLE:
                    if (in_acc)
                    begin
                        key_reg  <= s_axis_tdata[KB-1:0];
                        size_reg <= s_axis_tdata[87:64];
                        rem_reg  <= s_axis_tdata[87:64];
                        need_reg <= '0;
                        cnt_reg  <= '0;
                        blk_reg  <= '0;
                        ent_reg  <= '0;
                        head_reg <= END_LINK;
                        steps_reg <= '0;
                    end
                S_DIV:
                begin
                    res_reg <= '{div_status, 10'd0, 11'd0, 11'(used_count_reg)};
                    if (entry_count_reg < CW'(TABLE_ENTRIES))
                    begin
                        if (rem_reg != '0)
                        begin
                            if (need_reg != avail)
                            begin
                                need_reg <= need_reg + 1'b1;
                                rem_reg  <= (rem_reg > BLK_SIZE) ? rem_reg - BLK_SIZE : '0;
                            end
                        end
                        else if (need_reg == '0)
                            entry_count_reg <= entry_count_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    blk_reg <= blk_inc[BW-1:0];
                    if (!used_rd)
                    begin
                        if (head_reg == END_LINK) head_reg <= LW'(blk_reg);
                        prev_reg <= LW'(blk_reg);
                        cnt_reg  <= cnt_reg + 1'b1;
                        used_count_reg <= used_count_reg + 1'b1;
                        if (cnt_reg + 1'b1 == need_reg)
                        begin
                            entry_count_reg <= entry_count_reg + 1'b1;
                            res_reg.head_block <= 10'((head_reg == END_LINK) ?
                                                      LW'(blk_reg) : head_reg);
                            res_reg.chain_length <= 11'(cnt_reg + 1'b1);
                            res_reg.blocks_in_use <= 11'(used_count_reg + 1'b1);
                        end
                    end
                end
                S_FIND_RD:
                    res_reg <= '{ST_NOTFOUND, 10'd0, 11'd0, 11'(used_count_reg)};
                S_FIND:
                begin
                    if (key_hit)
                    begin
                        cur_reg <= head_rd;
                        res_reg.status <= ST_DELETED;
                        res_reg.head_block <= (head_rd == END_LINK) ? 10'd0 : 10'(head_rd);
                    end
                    else ent_reg <= ent_inc[EW-1:0];
                end
                S_WALK:
                begin
                    cur_reg   <= link_rd;
                    steps_reg <= steps_reg + 1'b1;
                    if (used_count_reg != '0) used_count_reg <= used_count_reg - 1'b1;
                    res_reg.chain_length <= 11'(steps_reg + 1'b1);
                    res_reg.blocks_in_use <= 11'((used_count_reg != '0) ?
                                                 used_count_reg - 1'b1 : used_count_reg);
                end
                S_MOVE_RD:
                    if (CW'(ent_inc) >= entry_count_reg)
                        entry_count_reg <= entry_count_reg - 1'b1;
                S_MOVE: ent_reg <= ent_inc[EW-1:0];
                default: ;
            endcase
        end
    end

    `LBFA_ASSERT_IMP(a_ready_idle, clk, rst_n, s_axis_tready, !m_axis_tvalid,
        "input taken while result pending")
    `LBFA_ASSERT_IMP(a_used_bound, clk, rst_n, 1'b1, used_count_reg <= LW'(DISK_BLOCKS),
        "used count beyond disk size")
    `LBFA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid, "result dropped")
endmodule

FILE: tb/tb.sv
// Self-checking testbench of the linked block file allocator.
// Depends on lbfa_pkg and linked_block_file_allocator; keeps its own model of
// the block map and the file table and compares every result with it.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbfa_pkg::*;

    localparam int NBLK = 1024;
    localparam int NENT = 1024;
    localparam int BLK_BYTES = 1024;
    localparam int RANDOM_REQUESTS = 270;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;   // file_key[63:0], byte_size[87:64]
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // status, head_block, chain_length, blocks_in_use, pad

    linked_block_file_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Shadow state of the allocator: block map, chain links and file table.
    bit           blk_busy [NBLK];
    int unsigned  blk_next [NBLK];
    logic [63:0]  file_keys [$];
    int unsigned  file_heads [$];
    int unsigned  blocks_taken;

    lbfa_result_t pending_results [$];
    int           fail_count = 0;

    // Works out the result of one request and updates the shadow state.
    function automatic lbfa_result_t allocate_or_free(logic kind, logic [63:0] key,
                                                      logic [23:0] nbytes);
        lbfa_result_t r;
        int unsigned need;
        int unsigned head;
        int unsigned prev;
        int unsigned cur;
        int unsigned nxt;
        int unsigned taken;
        int found;
        r = '0;
        taken = 0;
        head = NBLK;
        if (kind == KIND_CREATE)
        begin
            need = (nbytes + BLK_BYTES - 1) / BLK_BYTES;
            if (file_keys.size() >= NENT)
            begin
                r.status = ST_FULL;
            end
            else if (need > NBLK - blocks_taken)
            begin
                r.status = ST_NOSPACE;
            end
            else
            begin
                // Lowest free blocks first, linked in ascending order.
                prev = NBLK;
                for (int i = 0; i < NBLK && taken < need; i++)
                begin
                    if (!blk_busy[i])
                    begin
                        blk_busy[i] = 1'b1;
                        blk_next[i] = NBLK;
                        if (prev < NBLK) blk_next[prev] = i;
                        else head = i;
                        prev = i;
                        taken++;
                    end
                end
                blocks_taken += taken;
                file_keys.push_back(key);
                file_heads.push_back(head);
                r.status = ST_CREATED;
            end
        end
        else
        begin
            found = -1;
            foreach (file_keys[i])
            begin
                if (found < 0 && file_keys[i] == key) found = i;
            end
            if (found < 0)
            begin
                r.status = ST_NOTFOUND;
            end
            else
            begin
                head = file_heads[found];
                cur = head;
                while (cur < NBLK && taken < NBLK)
                begin
                    nxt = blk_next[cur];
                    if (blk_busy[cur])
                    begin
                        blk_busy[cur] = 1'b0;
                        if (blocks_taken > 0) blocks_taken--;
                    end
                    blk_next[cur] = NBLK;
                    taken++;
                    cur = nxt;
                end
                // Removing from the queue keeps the order of the rest.
                file_keys.delete(found);
                file_heads.delete(found);
                r.status = ST_DELETED;
            end
        end
        if (r.status == ST_CREATED || r.status == ST_DELETED)
        begin
            r.head_block = (head < NBLK) ? head[9:0] : 10'd0;
            r.chain_length = taken[10:0];
        end
        r.blocks_in_use = blocks_taken[10:0];
        return r;
    endfunction

    // Directed requests; a row with has_fixed carries its own expected result,
    // which must also agree with the shadow model.
    typedef struct {
        logic         kind;
        logic [63:0]  key;
        logic [23:0]  nbytes;
        bit           has_fixed;
        lbfa_result_t fixed;
    } stim_row_t;

    stim_row_t directed_rows [] = '{
        // Delete on an empty table.
        '{KIND_DELETE, 64'h41, 24'd0, 1, '{ST_NOTFOUND, 10'd0, 11'd0, 11'd0}},
        // Zero-size file: no chain.
        '{KIND_CREATE, 64'h41, 24'd0, 1, '{ST_CREATED, 10'd0, 11'd0, 11'd0}},
        // One byte takes one block, the lowest.
        '{KIND_CREATE, 64'h42, 24'd1, 1, '{ST_CREATED, 10'd0, 11'd1, 11'd1}},
        // Exactly one block.
        '{KIND_CREATE, 64'h43, 24'd1024, 1, '{ST_CREATED, 10'd1, 11'd1, 11'd2}},
        // One byte over a block boundary.
        '{KIND_CREATE, 64'h44, 24'd1025, 1, '{ST_CREATED, 10'd2, 11'd2, 11'd4}},
        // Largest size never fits.
        '{KIND_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF, 1,
          '{ST_NOSPACE, 10'd0, 11'd0, 11'd4}},
        // Deleting the zero-size file releases nothing.
        '{KIND_DELETE, 64'h41, 24'hFF_FFFF, 1, '{ST_DELETED, 10'd0, 11'd0, 11'd4}},
        // Duplicate names: the first one in table order goes.
        '{KIND_CREATE, 64'h42, 24'd3000, 0, '{default: '0}},
        '{KIND_DELETE, 64'h42, 24'd0, 1, '{ST_DELETED, 10'd0, 11'd1, 11'd6}},
        // Freed block 0 is reused first.
        '{KIND_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 24'd2048, 0, '{default: '0}},
        '{KIND_DELETE, 64'h43, 24'd0, 0, '{default: '0}},
        // Fill the disk to the last block exactly, then one more.
        '{KIND_CREATE, 64'h5A5A_5A5A_A5A5_A5A5, 24'd1041408, 0, '{default: '0}},
        '{KIND_CREATE, 64'h7, 24'd1, 1, '{ST_NOSPACE, 10'd0, 11'd0, 11'd1024}},
        '{KIND_CREATE, 64'h8, 24'd0, 1, '{ST_CREATED, 10'd0, 11'd0, 11'd1024}},
        '{KIND_DELETE, 64'h5A5A_5A5A_A5A5_A5A5, 24'd0, 0, '{default: '0}},
        '{KIND_DELETE, 64'h42, 24'd0, 0, '{default: '0}},
        '{KIND_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 24'd0, 0, '{default: '0}},
        '{KIND_DELETE, 64'h44, 24'd0, 0, '{default: '0}},
        '{KIND_DELETE, 64'h8, 24'd0, 1, '{ST_DELETED, 10'd0, 11'd0, 11'd0}}
    };

    logic [63:0] name_pool [8];

    // Sends one request, recording its expected result when accepted.
    task automatic send_request(logic kind, logic [63:0] key, logic [23:0] nbytes,
                                bit has_fixed, lbfa_result_t fixed);
        lbfa_result_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {nbytes, key};
        do @(posedge clk); while (!s_axis_tready);
        predicted = allocate_or_free(kind, key, nbytes);
        if (has_fixed && predicted != fixed)
        begin
            $display("%0t: directed row disagrees with model: expected %h, model %h",
                     $time, fixed, predicted);
            fail_count++;
        end
        pending_results.push_back(has_fixed ? fixed : predicted);
    endtask

    // Ends a burst with a random gap so pauses fall on every phase.
    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Receiver stall pattern: random stretches of free flow or of random stalls.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 40)) @(posedge clk) m_axis_tready <= 1'b1;
            end
            else
            begin
                repeat ($urandom_range(1, 8)) @(posedge clk)
                    m_axis_tready <= 1'($urandom_range(0, 1));
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        lbfa_result_t got;
        lbfa_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status        = m_axis_tdata[2:0];
            got.head_block    = m_axis_tdata[12:3];
            got.chain_length  = m_axis_tdata[23:13];
            got.blocks_in_use = m_axis_tdata[34:24];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                if (got.head_block !== want.head_block)
                    $display("%0t: head_block expected %0d actual %0d", $time,
                             want.head_block, got.head_block);
                if (got.chain_length !== want.chain_length)
                    $display("%0t: chain_length expected %0d actual %0d", $time,
                             want.chain_length, got.chain_length);
                if (got.blocks_in_use !== want.blocks_in_use)
                    $display("%0t: blocks_in_use expected %0d actual %0d", $time,
                             want.blocks_in_use, got.blocks_in_use);
                if (got !== want) fail_count++;
            end
        end
    end

    // Main stimulus.
    initial
    begin
        logic        kind;
        logic [63:0] key;
        logic [23:0] nbytes;
        int          pick;
        int          settle;
        lbfa_result_t none;
        none = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = KIND_CREATE;
        s_axis_tdata = '0;
        blocks_taken = 0;
        foreach (blk_busy[i]) blk_busy[i] = 1'b0;
        foreach (blk_next[i]) blk_next[i] = NBLK;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].kind, directed_rows[i].key,
                         directed_rows[i].nbytes, directed_rows[i].has_fixed,
                         directed_rows[i].fixed);
            sender_gap();
        end

        // Hold off until every result is back before the random part.
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);

        // A small pool of names makes deletes hit most of the time; some
        // names are random and some differ in a single bit.
        foreach (name_pool[i]) name_pool[i] = {$urandom, $urandom};
        name_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        name_pool[1] = 64'h0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 9) key = {$urandom, $urandom};
            else if (pick == 8)
                key = name_pool[$urandom_range(0, 7)] ^ (64'd1 << $urandom_range(0, 63));
            else key = name_pool[pick];
            kind = ($urandom_range(0, 99) < 55) ? KIND_CREATE : KIND_DELETE;
            case ($urandom_range(0, 9))
                0: nbytes = 24'd0;
                1: nbytes = 24'($urandom);
                2: nbytes = 24'($urandom_range(100000, 400000));
                default: nbytes = 24'($urandom_range(1, 40000));
            endcase
            send_request(kind, key, nbytes, 0, none);
            sender_gap();
        end
        s_axis_tvalid <= 1'b0;

        settle = 0;
        while (pending_results.size() != 0 && settle < 200000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (5000) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("linked_block_file_allocator: match");
        else
            $display("linked_block_file_allocator: mismatch");
        $finish;
    end

    // Watchdog: a time limit far over what about 300 requests need.
    initial
    begin
        #20ms;
        $display("linked_block_file_allocator: mismatch");
        $finish;
    end
endmodule
